FILE: rtl/core/ipnv_pkg.sv
package ipnv_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int COORD_W      = 32;
    localparam int DIST_W       = 2 * COORD_W;
    localparam int OUT_W        = 7;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_INSERT = 2'd2;

    typedef struct packed {
        logic load;
        logic clear_cnt;
        logic set_rej;
        logic pos_cnt;
        logic scan_init;
        logic scan_rd;
        logic calc_pos;
        logic shift_step;
        logic write_pt;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       empty;
        logic       scan_last;
        logic       pipe_busy;
        logic       shift_more;
        logic       shift_pend;
        logic       out_free;
    } t_sts;

endpackage

FILE: rtl/core/ipnv_ram.sv
module ipnv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ipnv_datapath.sv
module ipnv_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ipnv_pkg::t_cmd         i_cmd,
    output ipnv_pkg::t_sts         o_sts,
    input  logic [1:0]             i_func,
    input  logic signed [31:0]     i_coord_x,
    input  logic signed [31:0]     i_coord_y,
    input  logic                   i_ready,
    output logic                   o_valid,
    output logic [6:0]             o_position,
    output logic [6:0]             o_vertex_count,
    output logic                   o_full_reject
);

    import ipnv_pkg::*;

    function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] nd;
        d  = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        nd = -d;
        return d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

    logic [1:0]                r_func;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_pos;
    logic                      r_rej;

    logic                      r_v1, r_v2, r_v3, r_v4;
    logic [ADDR_W-1:0]         r_i1, r_i2, r_i3, r_i4;
    logic [COORD_W-1:0]        r_dx, r_dy;
    logic [DIST_W-1:0]         r_sx, r_sy, r_d;

    logic                      r_h1, r_h2;
    logic [ADDR_W-1:0]         r_b1, r_b2;
    logic [DIST_W-1:0]         r_d1, r_d2;

    logic                      r_sv;
    logic [ADDR_W-1:0]         r_sw;

    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_pos;
    logic [OUT_W-1:0]          r_out_cnt;
    logic                      r_out_rej;

    logic [2*COORD_W-1:0]      rd_data;
    logic [ADDR_W-1:0]         raddr;
    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [2*COORD_W-1:0]      wdata;
    logic [CNT_W-1:0]          idx_dec;
    logic [CNT_W-1:0]          cnt_last;
    logic [DIST_W:0]           dsum;
    logic [ADDR_W-1:0]         lo, hi;
    logic [CNT_W-1:0]          new_pos;

    assign idx_dec  = r_idx - 1'b1;
    assign cnt_last = r_cnt - 1'b1;
    assign raddr    = i_cmd.shift_step ? idx_dec[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign we       = r_sv || i_cmd.write_pt;
    assign waddr    = r_sv ? r_sw : r_pos[ADDR_W-1:0];
    assign wdata    = r_sv ? rd_data : {r_px, r_py};
    assign dsum     = {1'b0, r_sx} + {1'b0, r_sy};

    always_comb begin
        lo = (r_b1 < r_b2) ? r_b1 : r_b2;
        hi = (r_b1 < r_b2) ? r_b2 : r_b1;
        if (lo == '0 && CNT_W'(hi) == cnt_last) begin
            new_pos = r_cnt;
        end else begin
            new_pos = CNT_W'(hi);
        end
    end

    ipnv_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_px   <= i_coord_x;
            r_py   <= i_coord_y;
        end
        r_i1 <= r_idx[ADDR_W-1:0];
        r_i2 <= r_i1;
        r_dx <= abs_diff($signed(rd_data[2*COORD_W-1:COORD_W]), r_px);
        r_dy <= abs_diff($signed(rd_data[COORD_W-1:0]), r_py);
        r_i3 <= r_i2;
        r_sx <= r_dx * r_dx;
        r_sy <= r_dy * r_dy;
        r_i4 <= r_i3;
        r_d  <= dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
        if (r_v4) begin
            if (!r_h1 || r_d < r_d1) begin
                r_d2 <= r_d1;
                r_b2 <= r_b1;
                r_d1 <= r_d;
                r_b1 <= r_i4;
            end else if (!r_h2 || r_d < r_d2) begin
                r_d2 <= r_d;
                r_b2 <= r_i4;
            end
        end
        if (i_cmd.scan_init) begin
            r_b1 <= '0;
            r_b2 <= '0;
        end
        r_sw <= r_idx[ADDR_W-1:0];
        if (i_cmd.out_load) begin
            r_out_pos <= OUT_W'(r_pos);
            r_out_cnt <= OUT_W'(r_cnt);
            r_out_rej <= r_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_rej       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_h1        <= 1'b0;
            r_h2        <= 1'b0;
            r_sv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_sv <= i_cmd.shift_step;
            if (i_cmd.load) begin
                r_pos <= '0;
                r_rej <= 1'b0;
            end
            if (i_cmd.clear_cnt) begin
                r_cnt <= '0;
            end else if (i_cmd.write_pt) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.set_rej) begin
                r_rej <= 1'b1;
            end
            if (i_cmd.pos_cnt) begin
                r_pos <= r_cnt;
                r_idx <= r_cnt;
            end else if (i_cmd.calc_pos) begin
                r_pos <= new_pos;
                r_idx <= r_cnt;
            end else if (i_cmd.scan_init) begin
                r_idx <= '0;
            end else if (i_cmd.scan_rd) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.shift_step) begin
                r_idx <= idx_dec;
            end
            if (i_cmd.scan_init) begin
                r_h1 <= 1'b0;
                r_h2 <= 1'b0;
            end else if (r_v4) begin
                if (!r_h1 || r_d < r_d1) begin
                    r_h2 <= r_h1;
                    r_h1 <= 1'b1;
                end else if (!r_h2 || r_d < r_d2) begin
                    r_h2 <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.func       = r_func;
        o_sts.full       = (r_cnt >= CNT_W'(MAX_VERTICES));
        o_sts.empty      = (r_cnt == '0);
        o_sts.scan_last  = (r_idx == cnt_last);
        o_sts.pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4;
        o_sts.shift_more = (r_idx > r_pos);
        o_sts.shift_pend = r_sv;
        o_sts.out_free   = !r_out_valid || i_ready;
    end

    assign o_valid        = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_vertex_count = r_out_cnt;
    assign o_full_reject  = r_out_rej;

endmodule

FILE: rtl/core/ipnv_ctrl.sv
module ipnv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ipnv_pkg::t_sts i_sts,
    output ipnv_pkg::t_cmd o_cmd
);

    import ipnv_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_SHIFT  = 8'b0001_0000,
        S_WRITE  = 8'b0010_0000,
        S_DONE   = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (i_sts.func)
                    FUNC_CLEAR: begin
                        o_cmd.clear_cnt = 1'b1;
                    end
                    FUNC_APPEND, FUNC_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.set_rej = 1'b1;
                        end else if (i_sts.func == FUNC_APPEND || i_sts.empty) begin
                            o_cmd.pos_cnt = 1'b1;
                            n_state       = S_SHIFT;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.calc_pos = 1'b1;
                    n_state        = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_cmd.shift_step = 1'b1;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!i_sts.shift_pend) begin
                    o_cmd.write_pt = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/insert_point_between_nearest_vertices.sv
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_func, i_coord_x, i_coord_y
// output    out        o_valid / i_ready  o_position, o_vertex_count, o_full_reject
//
// Clear, reject and no-op go from the transfer through DECIDE and DONE to the result register.
// Append goes through DECIDE, SHIFT, WRITE and DONE; insert over the held vertices runs a scan
// pass, then a shift pass, through the one read port of the vertex RAM.
// Reset (i_rst_n low, synchronous) empties the polygon; the vertex RAM is not cleared.
// A pending result holds in the output register; the next item is taken meanwhile.
module insert_point_between_nearest_vertices (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [6:0]         o_position,
    output logic [6:0]         o_vertex_count,
    output logic               o_full_reject
);

    import ipnv_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ipnv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ipnv_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_vertex_count (o_vertex_count),
        .o_full_reject  (o_full_reject)
    );

endmodule
